// File: src/tlbpa_pkg.sv
// Shared constants, types and helper functions for the two-level bitmap page allocator.
package tlbpa_pkg;

  // Pool geometry. GROUP_SIZE is kept a multiple of 8 (byte-wise search).
  localparam int POOL_PAGES  = 1024;
  localparam int GROUP_SIZE  = 64;
  localparam int PAGE_SHIFT  = 12;

  localparam int GROUP_COUNT = (POOL_PAGES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int CHUNKS      = GROUP_SIZE / 8;

  localparam int IDX_W   = $clog2(POOL_PAGES);
  localparam int GRP_W   = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int OFF_W   = $clog2(GROUP_SIZE);
  localparam int CNT_W   = $clog2(GROUP_SIZE + 1);

  localparam int ADDR_W  = 32;
  localparam int BASE_W  = 20;

  // Width of the shared find-first-set unit
  localparam int PICK_A  = (GROUP_COUNT > CHUNKS) ? GROUP_COUNT : CHUNKS;
  localparam int PICK_W  = (PICK_A > 8) ? PICK_A : 8;
  localparam int PICK_IW = $clog2(PICK_W);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NO_FREE       = 2'd1;
  localparam logic [1:0] ST_OUT_OF_POOL   = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOCATED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRP,
    S_BYTE,
    S_BIT,
    S_CHK,
    S_FREE
  } state_t;

  typedef struct packed {
    logic               found;
    logic [PICK_IW-1:0] idx;
  } pick_t;

  // Pages held by group g (last group may be partial)
  function automatic logic [CNT_W-1:0] group_pages(input int g);
    int left;
    left = POOL_PAGES - g * GROUP_SIZE;
    return (left < GROUP_SIZE) ? CNT_W'(left) : CNT_W'(GROUP_SIZE);
  endfunction

  // Bits past the end of a partial group read as used
  function automatic logic [GROUP_SIZE-1:0] group_pad(input int g);
    logic [GROUP_SIZE-1:0] m;
    for (int b = 0; b < GROUP_SIZE; b++) begin
      m[b] = (b >= int'(group_pages(g)));
    end
    return m;
  endfunction

endpackage

// File: src/tlbpa_pick.sv
// Shared find-first-set unit used for group, byte and bit selection.
module tlbpa_pick (
  input  logic [tlbpa_pkg::PICK_W-1:0] req,
  output tlbpa_pkg::pick_t             res
);
  import tlbpa_pkg::*;

  always_comb begin
    res.found = |req;
    res.idx   = '0;
    for (int i = PICK_W - 1; i >= 0; i--) begin
      if (req[i]) begin
        res.idx = PICK_IW'(i);
      end
    end
  end

endmodule

// File: src/two_level_bitmap_page_allocator.sv
// Top level of the two-level bitmap page allocator: sequencer, bitmap RAM and group counts.
//
// Page allocator over a pool of POOL_PAGES pages of 2^PAGE_SHIFT bytes, starting
// at page cfg_pool_base_page. A request is taken when start is high and busy
// is low; in_opcode 0 allocates the lowest free page, 1 frees the page holding
// in_address. Exactly one result comes back, on out_page_address/out_status,
// valid for the single cycle out_valid is high; it cannot be held off, so the
// receiver must take it then. Steps: allocate does a group pick, a byte pick
// in the row read from the bitmap RAM, a bit pick plus row write-back, and the
// result; free does a range check plus row read, a bit test plus write-back, and
// the result. An allocate on a full pool, or a free outside the pool, goes to
// the result straight after its first step. The sequence is set by the bitmap
// RAM port and by the one find-first-set unit shared by all three pick steps.
// A new request may be presented in the cycle that carries the result.
// Status: 0 ok, 1 no free page, 2 address outside pool, 3 page not allocated;
// out_page_address is zero unless an allocate succeeded. The bitmap is cleared
// by reset at once through one valid bit per RAM row, so there is no clearing
// pass. cfg_pool_base_page is always ready and is meant to be written only
// while the block is idle.
module two_level_bitmap_page_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [tlbpa_pkg::ADDR_W-1:0]   in_address,
  // result channel
  output logic                           out_valid,
  output logic [tlbpa_pkg::ADDR_W-1:0]   out_page_address,
  output logic [1:0]                     out_status,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlbpa_pkg::BASE_W-1:0]   cfg_pool_base_page
);
  import tlbpa_pkg::*;

  // ---------------------------------------------------------------- state
  state_t                  state_r, state_nxt;
  logic [BASE_W-1:0]       base_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [GRP_W-1:0]        grp_r, grp_nxt;
  logic [CHUNK_W-1:0]      chunk_r, chunk_nxt;
  logic [OFF_W-1:0]        off_r, off_nxt;
  logic [GROUP_SIZE-1:0]   word_r;
  logic [CNT_W-1:0]        cnt_r [GROUP_COUNT];
  logic [GROUP_COUNT-1:0]  row_vld_r;

  logic                    out_valid_r;
  logic [ADDR_W-1:0]       out_page_address_r;
  logic [1:0]              out_status_r;

  // bitmap RAM: one row of GROUP_SIZE used bits per group
  logic [GROUP_SIZE-1:0]   mem [GROUP_COUNT];
  logic [GROUP_SIZE-1:0]   mem_rd_r;
  logic                    rd_vld_r;
  logic                    mem_re, mem_we;
  logic [GRP_W-1:0]        mem_ra;
  logic [GROUP_SIZE-1:0]   mem_wd;

  // sequencer actions
  logic                    done;
  logic [1:0]              done_status;
  logic [ADDR_W-1:0]       done_addr;
  logic                    cnt_inc, cnt_dec;

  // ---------------------------------------------------------------- shared pick unit
  logic [PICK_W-1:0]       pick_req;
  pick_t                   pick_res;

  tlbpa_pick u_pick (
    .req (pick_req),
    .res (pick_res)
  );

  // ---------------------------------------------------------------- datapath terms
  logic [PICK_W-1:0]       nonfull;
  logic [PICK_W-1:0]       chunk_open;
  logic [GROUP_SIZE-1:0]   eff_word;
  logic [7:0]              sel_byte;
  logic [OFF_W-1:0]        alloc_off;
  logic [IDX_W-1:0]        alloc_idx;
  logic [ADDR_W:0]         pg_ext, base_ext, diff_ext;
  logic                    in_pool;
  logic [IDX_W-1:0]        free_idx;

  always_comb begin
    nonfull = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      nonfull[g] = (cnt_r[g] != group_pages(g));
    end
  end

  // Row as seen by logic: never-written rows read as all free
  assign eff_word = (rd_vld_r ? mem_rd_r : '0) | group_pad(int'(grp_r));

  always_comb begin
    chunk_open = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      chunk_open[c] = ~&eff_word[c*8 +: 8];
    end
  end

  assign sel_byte  = word_r[int'(chunk_r)*8 +: 8];
  assign alloc_off = OFF_W'(32'(chunk_r) * 8 + 32'(pick_res.idx));
  assign alloc_idx = IDX_W'(32'(grp_r) * GROUP_SIZE + 32'(alloc_off));

  // Free range check on the full-width page number
  assign pg_ext   = (ADDR_W + 1)'(addr_r >> PAGE_SHIFT);
  assign base_ext = (ADDR_W + 1)'(base_r);
  assign diff_ext = pg_ext - base_ext;
  assign in_pool  = (pg_ext >= base_ext) && (diff_ext < (ADDR_W + 1)'(POOL_PAGES));
  assign free_idx = diff_ext[IDX_W-1:0];

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_opcode == OP_ALLOC) ? S_GRP : S_CHK;
        end
      end
      S_GRP:  state_nxt = pick_res.found ? S_BYTE : S_IDLE;
      S_BYTE: state_nxt = pick_res.found ? S_BIT : S_IDLE;
      S_BIT:  state_nxt = S_IDLE;
      S_CHK:  state_nxt = in_pool ? S_FREE : S_IDLE;
      S_FREE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- sequencer outputs
  always_comb begin
    pick_req    = '0;
    mem_re      = 1'b0;
    mem_ra      = grp_r;
    mem_we      = 1'b0;
    mem_wd      = word_r;
    done        = 1'b0;
    done_status = ST_OK;
    done_addr   = '0;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    grp_nxt     = grp_r;
    chunk_nxt   = chunk_r;
    off_nxt     = off_r;
    case (state_r)
      S_GRP: begin
        pick_req = nonfull;
        if (pick_res.found) begin
          grp_nxt = GRP_W'(pick_res.idx);
          mem_re  = 1'b1;
          mem_ra  = GRP_W'(pick_res.idx);
        end else begin
          done        = 1'b1;
          done_status = ST_NO_FREE;
        end
      end
      S_BYTE: begin
        pick_req = chunk_open;
        if (pick_res.found) begin
          chunk_nxt = CHUNK_W'(pick_res.idx);
        end else begin
          // count and bitmap disagree; cannot happen
          done        = 1'b1;
          done_status = ST_NO_FREE;
        end
      end
      S_BIT: begin
        pick_req    = PICK_W'(~sel_byte);
        mem_we      = 1'b1;
        mem_wd      = word_r | (GROUP_SIZE'(1) << alloc_off);
        cnt_inc     = 1'b1;
        done        = 1'b1;
        done_status = ST_OK;
        done_addr   = (ADDR_W'(base_r) + ADDR_W'(alloc_idx)) << PAGE_SHIFT;
      end
      S_CHK: begin
        if (in_pool) begin
          grp_nxt = GRP_W'(free_idx / GROUP_SIZE);
          off_nxt = OFF_W'(free_idx % GROUP_SIZE);
          mem_re  = 1'b1;
          mem_ra  = GRP_W'(free_idx / GROUP_SIZE);
        end else begin
          done        = 1'b1;
          done_status = ST_OUT_OF_POOL;
        end
      end
      S_FREE: begin
        done = 1'b1;
        if (eff_word[off_r]) begin
          mem_we      = 1'b1;
          mem_wd      = eff_word & ~(GROUP_SIZE'(1) << off_r);
          cnt_dec     = 1'b1;
          done_status = ST_OK;
        end else begin
          done_status = ST_NOT_ALLOCATED;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
        cnt_r[g] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_pool_base_page;
      end
      if (mem_we) begin
        row_vld_r[grp_r] <= 1'b1;
      end
      if (cnt_inc) begin
        cnt_r[grp_r] <= cnt_r[grp_r] + CNT_W'(1);
      end else if (cnt_dec) begin
        cnt_r[grp_r] <= cnt_r[grp_r] - CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      addr_r <= in_address;
    end
    grp_r   <= grp_nxt;
    chunk_r <= chunk_nxt;
    off_r   <= off_nxt;
    if (state_r == S_BYTE) begin
      word_r <= eff_word;
    end
    if (done) begin
      out_page_address_r <= done_addr;
      out_status_r       <= done_status;
    end
  end

  // bitmap RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[grp_r] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
      rd_vld_r <= row_vld_r[mem_ra];
    end
  end

  // ---------------------------------------------------------------- ports
  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_page_address = out_page_address_r;
  assign out_status       = out_status_r;

  // ---------------------------------------------------------------- assertions
  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != S_IDLE))
    else $error("result strobe without a request in flight");

  a_request_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not start the sequencer");

  a_group_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BIT |-> cnt_r[grp_r] < group_pages(int'(grp_r)))
    else $error("allocating into a full group");

  a_zero_addr_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_page_address == '0)
    else $error("nonzero page address on failed request");

endmodule

// File: bench/tb_two_level_bitmap_page_allocator.sv
// Self-checking bench for the two-level bitmap page allocator: directed and random requests.
`timescale 1ns / 100ps

module tb_two_level_bitmap_page_allocator;
  import tlbpa_pkg::*;

  // One request for the allocator, plus the idle cycles the driver waits before it.
  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    int unsigned       gap;
  } page_req_t;

  // One result as the allocator should report it.
  typedef struct {
    logic [ADDR_W-1:0] page_address;
    logic [1:0]        status;
  } page_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_opcode = OP_ALLOC;
  logic [ADDR_W-1:0] in_address = '0;
  logic              out_valid;
  logic [ADDR_W-1:0] out_page_address;
  logic [1:0]        out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BASE_W-1:0] cfg_pool_base_page = '0;

  // Mirror of the allocator: used bit per page, used count per group, pool base.
  bit          page_taken [POOL_PAGES];
  int          group_fill [GROUP_COUNT];
  logic [BASE_W-1:0] pool_base = '0;

  page_req_t    pending_reqs[$];
  page_result_t expected_results[$];

  int n_fail = 0;
  int n_accepted = 0;
  int n_settings = 1;
  int status_seen [4] = '{0, 0, 0, 0};

  // Driver scratch
  page_req_t next_req;
  logic      next_start;
  int        hold_cnt = -1;

  two_level_bitmap_page_allocator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_page_address   (out_page_address),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_pool_base_page (cfg_pool_base_page)
  );

  always #5 clk = ~clk;

  // Counts a failure; only the first ten are printed.
  task automatic log_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Applies one accepted request to the mirror and returns what the block must answer.
  function automatic page_result_t predict_page_result(input logic op,
                                                       input logic [ADDR_W-1:0] addr);
    page_result_t r;
    logic [63:0]  page;
    logic [63:0]  full_addr;
    int           g;
    int           p;
    int           idx;
    r.page_address = '0;
    r.status       = ST_NO_FREE;
    if (op == OP_ALLOC) begin
      // First group that is not full; a partial last group is full at its own size.
      g = 0;
      while (g < GROUP_COUNT && group_fill[g] >=
             ((POOL_PAGES - g * GROUP_SIZE < GROUP_SIZE) ? POOL_PAGES - g * GROUP_SIZE
                                                         : GROUP_SIZE)) begin
        g++;
      end
      if (g < GROUP_COUNT) begin
        // First free page inside that group
        p = g * GROUP_SIZE;
        while (p < POOL_PAGES && p < (g + 1) * GROUP_SIZE && page_taken[p]) begin
          p++;
        end
        if (p < POOL_PAGES && p < (g + 1) * GROUP_SIZE) begin
          page_taken[p] = 1'b1;
          group_fill[g]++;
          // Pages past the 32-bit range come back under a truncated address.
          full_addr      = (64'(pool_base) + 64'(p)) << PAGE_SHIFT;
          r.page_address = full_addr[ADDR_W-1:0];
          r.status       = ST_OK;
        end
      end
    end else begin
      // Range check uses the full-width pool bounds, offset bits dropped.
      page = 64'(addr) >> PAGE_SHIFT;
      if (page < 64'(pool_base) || page >= 64'(pool_base) + 64'(POOL_PAGES)) begin
        r.status = ST_OUT_OF_POOL;
      end else begin
        idx = int'(page - 64'(pool_base));
        if (!page_taken[idx]) begin
          // Double free: nothing changes
          r.status = ST_NOT_ALLOCATED;
        end else begin
          page_taken[idx] = 1'b0;
          group_fill[idx / GROUP_SIZE]--;
          r.status = ST_OK;
        end
      end
    end
    return r;
  endfunction

  // Driver: presents queued requests, predicts each one on the edge that takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      in_opcode  <= OP_ALLOC;
      in_address <= '0;
      hold_cnt   = -1;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_results.push_back(predict_page_result(in_opcode, in_address));
        n_accepted++;
        next_start = 1'b0;
      end
      // Start stays high back to back when the next request has no gap.
      if (!next_start && pending_reqs.size() > 0) begin
        if (hold_cnt < 0) begin
          hold_cnt = int'(pending_reqs[0].gap);
        end
        if (hold_cnt == 0) begin
          next_req   = pending_reqs.pop_front();
          in_opcode  <= next_req.op;
          in_address <= next_req.addr;
          next_start = 1'b1;
          hold_cnt   = -1;
        end else begin
          hold_cnt--;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      status_seen[out_status]++;
      if (expected_results.size() == 0) begin
        log_failure($sformatf("result with no request outstanding: addr %08h status %0d",
                              out_page_address, out_status));
      end else if (out_page_address !== expected_results[0].page_address ||
                   out_status !== expected_results[0].status) begin
        log_failure($sformatf("expected addr %08h status %0d, got addr %08h status %0d",
                              expected_results[0].page_address, expected_results[0].status,
                              out_page_address, out_status));
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Waits until every request is taken and answered, then lets the pipeline settle.
  task automatic drain();
    do @(negedge clk); while (pending_reqs.size() != 0 || start ||
                              expected_results.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // Writes the pool base through its own channel; only called while the block is idle.
  task automatic write_pool_base(input logic [BASE_W-1:0] value);
    @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_pool_base_page <= value;
    do @(posedge clk); while (!cfg_ready);
    pool_base = value;
    n_settings++;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_request(input logic op, input logic [ADDR_W-1:0] addr);
    page_req_t q;
    q.op   = op;
    q.addr = addr;
    q.gap  = $urandom_range(5);
    pending_reqs.push_back(q);
  endtask

  // Random page index whose used bit matches want_used, or -1 if none.
  function automatic int find_page(input bit want_used);
    int first;
    int i;
    first = $urandom_range(POOL_PAGES - 1);
    for (int k = 0; k < POOL_PAGES; k++) begin
      i = (first + k) % POOL_PAGES;
      if (page_taken[i] == want_used) begin
        return i;
      end
    end
    return -1;
  endfunction

  // alloc_pct % allocs; frees mostly of used pages, else double frees, out-of-pool, noise.
  function automatic page_req_t make_request(input int alloc_pct, input bit no_gaps);
    page_req_t         q;
    int                pick;
    int                idx;
    int                top;
    logic [ADDR_W-1:0] pg;
    q.gap  = no_gaps ? 0 : $urandom_range(5);
    q.addr = $urandom;
    if ($urandom_range(99) < alloc_pct) begin
      q.op = OP_ALLOC;
      return q;
    end
    q.op = OP_FREE;
    pick = $urandom_range(99);
    idx  = -1;
    pg   = q.addr >> PAGE_SHIFT;
    if (pick < 60) begin
      idx = find_page(1'b1);
    end else if (pick < 75) begin
      idx = find_page(1'b0);
    end
    top = int'(pool_base) + POOL_PAGES;
    if (idx >= 0) begin
      pg = ADDR_W'(int'(pool_base) + idx);
    end else if (pick < 90) begin
      // Anywhere outside the pool on either side, where the address space allows
      if (pool_base != 0 && ($urandom_range(1) == 1 || top > (1 << (ADDR_W - PAGE_SHIFT)) - 1))
      begin
        pg = ADDR_W'($urandom_range(int'(pool_base) - 1, 0));
      end else if (top <= (1 << (ADDR_W - PAGE_SHIFT)) - 1) begin
        pg = ADDR_W'($urandom_range((1 << (ADDR_W - PAGE_SHIFT)) - 1, top));
      end
    end
    // Keep random offset bits below the page
    q.addr = (pg << PAGE_SHIFT) | (q.addr & ((ADDR_W'(1) << PAGE_SHIFT) - 1));
    return q;
  endfunction

  // One pool setting with random traffic; stretches of 40 requests may run gap-free.
  task automatic run_random_phase(input logic [BASE_W-1:0] base, input int count,
                                  input int alloc_pct);
    bit no_gaps;
    no_gaps = 1'b0;
    write_pool_base(base);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        no_gaps = ($urandom_range(3) == 0);
      end
      // Short queue so free targets follow the mirror closely
      while (pending_reqs.size() >= 4) @(negedge clk);
      pending_reqs.push_back(make_request(alloc_pct, no_gaps));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset base of zero: first-fit order, hole refill, masking and range edges.
    queue_request(OP_ALLOC, 32'h0000_0000);
    queue_request(OP_ALLOC, 32'hFFFF_FFFF);
    queue_request(OP_ALLOC, 32'h1234_5678);
    queue_request(OP_FREE,  32'h0000_1000);
    queue_request(OP_FREE,  32'h0000_1ABC);  // same page again: double free
    queue_request(OP_ALLOC, 32'h0000_0000);  // refills the hole at page 1
    queue_request(OP_FREE,  32'h0000_2FFF);  // offset bits dropped
    queue_request(OP_FREE,  32'h003F_FFFF);  // last pool page, never used
    queue_request(OP_FREE,  32'h0040_0000);  // first page past the pool
    queue_request(OP_FREE,  32'hFFFF_FFFF);
    queue_request(OP_FREE,  32'h0000_0000);
    drain();

    // Top base: the second allocation wraps past 32 bits and cannot be freed again.
    write_pool_base(20'hFFFFF);
    queue_request(OP_ALLOC, 32'h0000_0000);
    queue_request(OP_ALLOC, 32'h0000_0000);
    queue_request(OP_FREE,  32'h0000_1000);  // low address below the pool
    queue_request(OP_FREE,  32'hFFFF_F000);
    queue_request(OP_FREE,  32'hFFFF_EFFF);  // one byte below the pool
    queue_request(OP_FREE,  32'hFFFF_F123);  // double free with offset
    drain();

    // Random phases; the fourth is nearly all allocations.
    run_random_phase(BASE_W'($urandom), 280, 60);
    run_random_phase(20'hFFC00, 280, 75);
    run_random_phase(20'hFFE00, 280, 85);
    run_random_phase(20'h00000, 420, 97);
    run_random_phase(BASE_W'($urandom), 140, 30);

    if (expected_results.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Covered %0d requests over %0d pool base settings, %0d mismatches.",
             n_accepted, n_settings, n_fail);
    $display("Results seen: ok %0d, no free page %0d, outside pool %0d, not allocated %0d.",
             status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_OUT_OF_POOL],
             status_seen[ST_NOT_ALLOCATED]);
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout: %0d requests taken, %0d results outstanding.",
             n_accepted, expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
